// ----- hw/rtl/rmth_pkg.sv -----
// shared constants and the order function for the running median block
`default_nettype none
package rmth_pkg;
  localparam int unsigned HeapDepthDef = 512;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 11;

  // signed order check: a ranks above b in a max or a min heap
  function automatic logic ranks_above(input logic is_max, input logic [ValueW-1:0] a,
                                       input logic [ValueW-1:0] b);
    logic gt;
    logic lt;
    gt = $signed(a) > $signed(b);
    lt = $signed(a) < $signed(b);
    return is_max ? gt : lt;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/rmth_ram.sv -----
// generic single port ram with registered read
`default_nettype none
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/running_median_two_heaps.sv -----
// top level of the two-heap running median engine
//
// channel | direction | ports                          | handshake
// --------+-----------+--------------------------------+---------------------------
// item in | in        | value_i                        | start_i high, busy_o low
// result  | out       | median_o, count_o, full_res_o  | done_o strobe, one cycle
//
// one item: both roots are read and the path is picked, then an optional sift-down
// with the steps left read, right read, compare and move per level and a close,
// a sift-up with the steps parent read, compare and move per level between an open
// and a close, then the median read
// a dropped item goes straight to the median read; busy_o is low in the done_o cycle
// the single port of each heap ram and the one shared compare set the number of steps
// the result cannot be stalled
// reset clears sizes, control and data registers; heap entries are only read
// below the current size, so heap contents need no clearing
`default_nettype none
module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int unsigned HeapDepth = HeapDepthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [ValueW-1:0]      median_o,
  output logic        [CountW-1:0]      count_o,
  output logic                          full_res_o
);
  localparam int unsigned AW = $clog2(HeapDepth);
  localparam int unsigned SW = AW + 1;        // size up to HeapDepth
  localparam logic [SW-1:0] DepthS = SW'(HeapDepth);

  typedef enum logic [3:0] {
    S_IDLE, S_RROOT, S_DECIDE, S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_DN_WR, S_DN_END,
    S_UP_ST, S_UP_RD, S_UP_CMP, S_UP_SWP, S_UP_FIN, S_MED_RD, S_MED
  } state_e;

  state_e          state_q;
  logic [SW-1:0]   lo_n_q, up_n_q;
  logic [ValueW-1:0] v_q;       // value being sifted
  logic [ValueW-1:0] moved_q;   // old root that crosses over
  logic [ValueW-1:0] lc_q, rc_q, pv_q;
  logic [AW-1:0]   pos_q, par_q;
  logic            dn_low_q;    // sift-down heap is the lower (max) heap
  logic            up_low_q;    // push heap is the lower heap
  logic            use_r_q;     // right child is the pick
  logic [ValueW-1:0] med_q;
  logic            full_q;

  // ram ports
  logic            lo_we, up_we;
  logic [AW-1:0]   lo_a, up_a;
  logic [ValueW-1:0] lo_wd, up_wd, lo_rd, up_rd;

  rmth_ram #(.Width(ValueW), .Depth(HeapDepth)) u_lo (
    .clk_i, .we_i(lo_we), .addr_i(lo_a), .wdata_i(lo_wd), .rdata_o(lo_rd));
  rmth_ram #(.Width(ValueW), .Depth(HeapDepth)) u_up (
    .clk_i, .we_i(up_we), .addr_i(up_a), .wdata_i(up_wd), .rdata_o(up_rd));

  // sift-down child indexes, wide so overflow past the size is seen
  logic [SW:0] lidx, ridx;
  logic [SW-1:0] dn_n;
  logic [ValueW-1:0] dn_rd, up_heap_rd;
  assign lidx = (SW+1)'({pos_q, 1'b1});
  assign ridx = lidx + (SW+1)'(1);
  assign dn_n = dn_low_q ? lo_n_q : up_n_q;
  assign dn_rd = dn_low_q ? lo_rd : up_rd;
  assign up_heap_rd = up_low_q ? lo_rd : up_rd;

  // picked child of the sift-down
  logic [ValueW-1:0] pick_v;
  assign pick_v = use_r_q ? rc_q : lc_q;

  // the one shared compare, operands picked by state
  logic              cmp_max, cmp_hit;
  logic [ValueW-1:0] cmp_a, cmp_b;

  always_comb begin
    cmp_max = dn_low_q;
    cmp_a   = v_q;
    cmp_b   = pick_v;
    unique case (state_q)
      // root of the heap a plain push would not fill, against the value
      S_DECIDE: begin
        cmp_max = (lo_n_q != up_n_q);
        cmp_a   = (lo_n_q == up_n_q) ? up_rd : lo_rd;
        cmp_b   = v_q;
      end
      // left child against right child
      S_DN_CMP: begin
        cmp_max = dn_low_q;
        cmp_a   = lc_q;
        cmp_b   = dn_rd;
      end
      // sifted value against its parent
      S_UP_CMP: begin
        cmp_max = up_low_q;
        cmp_a   = v_q;
        cmp_b   = up_heap_rd;
      end
      // sifted value against the picked child
      default: begin
        cmp_max = dn_low_q;
        cmp_a   = v_q;
        cmp_b   = pick_v;
      end
    endcase
  end

  assign cmp_hit = ranks_above(cmp_max, cmp_a, cmp_b);

  // ram address and write mux
  logic          w_en;
  logic [AW-1:0] r_a;
  logic [ValueW-1:0] w_d;
  logic          w_low;

  always_comb begin
    w_en = 1'b0;
    w_d = v_q;
    r_a = '0;
    w_low = 1'b0;
    unique case (state_q)
      S_DN_RD_L: r_a = lidx[AW-1:0];
      S_DN_RD_R: r_a = ridx[AW-1:0];
      S_DN_WR: begin
        // child moves up into the hole unless the value stops here
        w_en = !cmp_hit;
        w_low = dn_low_q;
        w_d = pick_v;
      end
      S_DN_END: begin
        w_en = 1'b1;
        w_low = dn_low_q;
      end
      S_UP_ST: begin
        // push into an empty heap lands at the root at once
        w_en = (pos_q == '0);
        w_low = up_low_q;
      end
      S_UP_RD: r_a = par_q;
      S_UP_SWP: begin
        w_en = 1'b1;
        w_low = up_low_q;
        w_d = pv_q;
      end
      S_UP_FIN: begin
        w_en = 1'b1;
        w_low = up_low_q;
      end
      default: begin
        r_a = '0;
      end
    endcase
  end

  assign lo_we = w_en && w_low;
  assign up_we = w_en && !w_low;
  assign lo_a  = lo_we ? pos_q : r_a;
  assign up_a  = up_we ? pos_q : r_a;
  assign lo_wd = w_d;
  assign up_wd = w_d;

  logic [AW-1:0] lo_last, up_last;
  assign lo_last = lo_n_q[AW-1:0];
  assign up_last = up_n_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lo_n_q   <= '0;
      up_n_q   <= '0;
      v_q      <= '0;
      moved_q  <= '0;
      lc_q     <= '0;
      rc_q     <= '0;
      pv_q     <= '0;
      pos_q    <= '0;
      par_q    <= '0;
      dn_low_q <= 1'b0;
      up_low_q <= 1'b0;
      use_r_q  <= 1'b0;
      med_q    <= '0;
      full_q   <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            v_q    <= value_i;
            full_q <= 1'b0;
            if (lo_n_q == DepthS && up_n_q == DepthS) begin
              full_q  <= 1'b1;
              state_q <= S_MED_RD;
            end else begin
              state_q <= S_RROOT;
            end
          end
        end
        // both roots are addressed here
        S_RROOT: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (lo_n_q == up_n_q) begin
            // value above the upper root swaps into the upper heap
            up_low_q <= 1'b1;
            if (lo_n_q != '0 && cmp_hit) begin
              dn_low_q <= 1'b0;
              moved_q  <= up_rd;
              pos_q    <= '0;
              state_q  <= S_DN_RD_L;
            end else begin
              pos_q   <= lo_last;
              state_q <= S_UP_ST;
            end
          end else begin
            // value below the lower root swaps into the lower heap
            up_low_q <= 1'b0;
            if (cmp_hit) begin
              dn_low_q <= 1'b1;
              moved_q  <= lo_rd;
              pos_q    <= '0;
              state_q  <= S_DN_RD_L;
            end else begin
              pos_q   <= up_last;
              state_q <= S_UP_ST;
            end
          end
        end
        // sift-down of v_q from pos_q, the hole is filled by moved children
        S_DN_RD_L: begin
          if (lidx >= (SW+1)'(dn_n)) begin
            state_q <= S_DN_END;
          end else begin
            state_q <= S_DN_RD_R;
          end
        end
        S_DN_RD_R: begin
          lc_q    <= dn_rd;
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          rc_q    <= dn_rd;
          use_r_q <= (ridx < (SW+1)'(dn_n)) && !cmp_hit;
          state_q <= S_DN_WR;
        end
        S_DN_WR: begin
          if (cmp_hit) begin
            state_q <= S_DN_END;
          end else begin
            pos_q   <= use_r_q ? ridx[AW-1:0] : lidx[AW-1:0];
            state_q <= S_DN_RD_L;
          end
        end
        // v_q lands in the hole, the old root goes on to the other heap
        S_DN_END: begin
          v_q     <= moved_q;
          pos_q   <= up_low_q ? lo_last : up_last;
          state_q <= S_UP_ST;
        end
        // push: new slot at the end, sift-up with a hole
        S_UP_ST: begin
          if (up_low_q) lo_n_q <= lo_n_q + SW'(1);
          else          up_n_q <= up_n_q + SW'(1);
          par_q   <= AW'((pos_q - AW'(1)) >> 1);
          state_q <= (pos_q == '0) ? S_MED_RD : S_UP_RD;
        end
        S_UP_RD: state_q <= S_UP_CMP;
        S_UP_CMP: begin
          pv_q <= up_heap_rd;
          if (cmp_hit) begin
            state_q <= S_UP_SWP;
          end else begin
            state_q <= S_UP_FIN;
          end
        end
        S_UP_SWP: begin
          // parent value moves down; the hole moves up
          pos_q   <= par_q;
          par_q   <= AW'((par_q - AW'(1)) >> 1);
          state_q <= (par_q == '0) ? S_UP_FIN : S_UP_RD;
        end
        S_UP_FIN: state_q <= S_MED_RD;
        S_MED_RD: state_q <= S_MED;
        S_MED: begin
          med_q   <= (lo_n_q != '0) ? lo_rd : '0;
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [SW:0] total_n;
  assign total_n = {1'b0, lo_n_q} + {1'b0, up_n_q};

  assign busy_o     = (state_q != S_IDLE);
  assign median_o   = med_q;
  assign count_o    = CountW'(total_n);
  assign full_res_o = full_q;
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the two-heap running median block
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import rmth_pkg::*;
();

  localparam int unsigned Depth = HeapDepthDef;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [ValueW-1:0] median;
    logic [CountW-1:0]        count;
    logic                     full;
  } median_res_t;

  // directed row: value plus an optional typed-in result
  typedef struct {
    logic signed [ValueW-1:0] value;
    bit                       typed;
    median_res_t              res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [ValueW-1:0] value_i = '0;
  logic busy_o, done_o, full_res_o;
  logic signed [ValueW-1:0] median_o;
  logic [CountW-1:0] count_o;

  running_median_two_heaps dut (
    .clk_i, .rst_ni, .start_i, .value_i, .busy_o, .done_o, .median_o, .count_o,
    .full_res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: the two halves as heaps of signed values
  logic signed [ValueW-1:0] low_half[Depth];
  logic signed [ValueW-1:0] high_half[Depth];
  int unsigned low_n, high_n;
  median_res_t pending_q[$];
  bit failed = 1'b0;
  int unsigned idle_cycles = 0;

  // true when a sits nearer the root than b
  function automatic bit above(bit is_max, logic signed [ValueW-1:0] a,
                               logic signed [ValueW-1:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_push(bit is_max, logic signed [ValueW-1:0] v);
    int unsigned pos, up;
    logic signed [ValueW-1:0] t;
    if (is_max) begin
      pos = low_n; low_half[pos] = v; low_n++;
    end else begin
      pos = high_n; high_half[pos] = v; high_n++;
    end
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (is_max) begin
        if (!above(1, low_half[pos], low_half[up])) break;
        t = low_half[pos]; low_half[pos] = low_half[up]; low_half[up] = t;
      end else begin
        if (!above(0, high_half[pos], high_half[up])) break;
        t = high_half[pos]; high_half[pos] = high_half[up]; high_half[up] = t;
      end
      pos = up;
    end
  endtask

  // swap v into the root, sift down, hand back the old root
  task automatic heap_swap_root(bit is_max, logic signed [ValueW-1:0] v,
                                output logic signed [ValueW-1:0] old);
    int unsigned pos, l, r, pick, n;
    logic signed [ValueW-1:0] h[Depth];
    logic signed [ValueW-1:0] t;
    if (is_max) begin h = low_half; n = low_n; end
    else begin h = high_half; n = high_n; end
    old = h[0];
    h[0] = v;
    pos = 0;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      if (l >= n) break;
      pick = l;
      if (r < n && !above(is_max, h[l], h[r])) pick = r;
      if (above(is_max, h[pos], h[pick])) break;
      t = h[pos]; h[pos] = h[pick]; h[pick] = t;
      pos = pick;
    end
    if (is_max) low_half = h;
    else high_half = h;
  endtask

  function automatic median_res_t median_now(bit full);
    median_res_t r;
    r.median = (low_n > 0) ? low_half[0] : '0;
    r.count = CountW'(low_n + high_n);
    r.full = full;
    return r;
  endfunction

  task automatic median_update(logic signed [ValueW-1:0] v, output median_res_t r);
    logic signed [ValueW-1:0] moved;
    bit full;
    full = 1'b0;
    if (low_n + high_n >= 2 * Depth) begin
      full = 1'b1;   // storage full, item dropped
    end else if (low_n == high_n) begin
      // tie with the upper root stays in the lower half
      if (low_n > 0 && above(0, high_half[0], v)) begin
        heap_swap_root(0, v, moved);
        heap_push(1, moved);
      end else begin
        heap_push(1, v);
      end
    end else begin
      // tie with the lower root goes to the upper half
      if (above(1, low_half[0], v)) begin
        heap_swap_root(1, v, moved);
        heap_push(0, moved);
      end else begin
        heap_push(0, v);
      end
    end
    r = median_now(full);
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    median_res_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: median %0d count %0d", median_o, count_o);
        failed = 1'b1;
      end else begin
        exp_r = pending_q.pop_front();
        if (median_o !== exp_r.median) begin
          $error("median: expected %0d, got %0d", exp_r.median, median_o);
          failed = 1'b1;
        end
        if (count_o !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, count_o);
          failed = 1'b1;
        end
        if (full_res_o !== exp_r.full) begin
          $error("full_res: expected %0b, got %0b", exp_r.full, full_res_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one item, hold it until accepted; start stays high across items
  task automatic send_item(logic signed [ValueW-1:0] v, bit typed, median_res_t typed_r);
    median_res_t r;
    start_i <= 1'b1;
    value_i <= v;
    // busy_o only moves at the rising edge, so it is stable here
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    median_update(v, r);
    if (typed && r != typed_r) begin
      $error("typed row disagrees with predictor for value %0d", v);
      failed = 1'b1;
    end
    pending_q.insert(pending_q.size(), typed ? typed_r : r);
    @(negedge clk_i);
  endtask

  task automatic pause(bit allow);
    int unsigned gap;
    if (allow && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start_i <= 1'b0;
      value_i <= $urandom();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15) - 8;             // lots of ties
      1: return {1'b1, 31'($urandom_range(0, 3))};      // near the minimum
      2: return {1'b0, {29{1'b1}}, 2'($urandom_range(0, 3))};
      default: return $urandom();
    endcase
  endfunction

  dir_row_t dir_rows[$];
  median_res_t none_r = '0;

  task automatic add_row(logic signed [ValueW-1:0] v, bit typed,
                         logic signed [ValueW-1:0] m, int unsigned c);
    dir_row_t row;
    row.value = v;
    row.typed = typed;
    row.res.median = m;
    row.res.count = CountW'(c);
    row.res.full = 1'b0;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    int unsigned fill_n;
    int unsigned drain;
    // extremes and ties; first row after reset reads straight off
    add_row(32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
    add_row(32'sh8000_0000, 1, 32'sh8000_0000, 2);
    add_row(32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 3);
    add_row(32'sh8000_0000, 1, 32'sh8000_0000, 4);
    add_row(0, 0, 0, 0);
    add_row(0, 0, 0, 0);
    add_row(-1, 0, 0, 0);
    add_row(1, 0, 0, 0);
    add_row(0, 0, 0, 0);
    add_row(32'sh5555_5555, 0, 0, 0);
    add_row(32'shAAAA_AAAA, 0, 0, 0);
    add_row(-1, 0, 0, 0);
    add_row(-1, 0, 0, 0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
      pause(1);
    end

    // hold off until every result is back
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);

    // random: fill to full, then dropped items, with idling early on
    fill_n = 2 * Depth - (low_n + high_n);
    for (int unsigned i = 0; i < fill_n + 40; i++) begin
      send_item(rand_value(), 0, none_r);
      pause(i < fill_n - 100);
    end
    // full items keep the state; the last stretch runs without gaps
    for (int unsigned i = 0; i < 400; i++) send_item(rand_value(), 0, none_r);
    start_i <= 1'b0;

    drain = 0;
    while (pending_q.size() != 0 && drain < WatchLimit) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (100) @(negedge clk_i);
    if (!failed && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_q.size() != 0) $error("%0d results never arrived", pending_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
